// File: sv/rmsu_pkg.sv
// shared types and codes for the repeat message suppressor
package rmsu_pkg;

    typedef enum logic [2:0] {
        VC_FIRST       = 3'd0,
        VC_LEN_CHANGED = 3'd1,
        VC_CONTENT     = 3'd2,
        VC_DUPLICATE   = 3'd3,
        VC_DISABLED    = 3'd4,
        VC_TOO_LONG    = 3'd5
    } verdict_code_t;

    localparam logic CFG_HEADER_OFFSET = 1'b0;
    localparam logic CFG_FILTER_ENABLE = 1'b1;

    // one byte on its way from the tracker to the verdict stage
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       cmp_en;
        logic       too_long;
        logic       first;
        logic       disabled;
        logic       len_changed;
    } rmsu_item_t;

endpackage

// File: sv/rmsu_ram.sv
// generic single write port ram with registered read
module rmsu_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents when both ports hit the same entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rmsu_track.sv
// byte position tracking, store addressing and per-message bookkeeping
module rmsu_track
    import rmsu_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096,
    parameter int ADDR_W = $clog2(MAX_MESSAGE_BYTES)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        header_offset,
    input  logic              filter_enable,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    input  logic              item_take,
    output logic              item_valid,
    output rmsu_item_t        item,
    output logic              ram_wr_en,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_addr
);

    localparam int POS_CAP = MAX_MESSAGE_BYTES + 257;
    localparam int POS_W   = $clog2(POS_CAP + 1);
    localparam int LEN_W   = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [POS_W-1:0] POS_CAP_V = POS_W'(POS_CAP);
    localparam logic [POS_W-1:0] MAX_V     = POS_W'(MAX_MESSAGE_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             ovf_reg, ovf_next;
    logic             have_prev_reg, have_prev_next;
    logic [LEN_W-1:0] prev_len_reg, prev_len_next;
    logic             valid_reg, valid_next;
    rmsu_item_t       item_reg, item_next;

    logic [POS_W-1:0] hdr_ext, prev_len_ext, idx_full, pos_inc, len_full;
    logic             accept, past_hdr, in_range, store_hit, overflow_now;

    assign s_ready = !valid_reg || item_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        hdr_ext      = POS_W'(header_offset);
        prev_len_ext = POS_W'(prev_len_reg);
        past_hdr     = pos_reg >= hdr_ext;
        idx_full     = pos_reg - hdr_ext;
        in_range     = idx_full < MAX_V;
        store_hit    = past_hdr && in_range;
        overflow_now = ovf_reg || (past_hdr && !in_range);
        pos_inc      = (pos_reg < POS_CAP_V) ? pos_reg + POS_W'(1) : pos_reg;
        len_full     = (pos_inc > hdr_ext) ? pos_inc - hdr_ext : '0;
    end

    assign ram_addr  = idx_full[ADDR_W-1:0];
    assign ram_wr_en = accept && store_hit;
    assign ram_rd_en = accept;

    always_comb begin
        item_next.data        = s_data_byte;
        item_next.last        = s_last_byte;
        item_next.cmp_en      = have_prev_reg && store_hit && (idx_full < prev_len_ext);
        item_next.too_long    = overflow_now;
        item_next.first       = !have_prev_reg;
        item_next.disabled    = !filter_enable;
        item_next.len_changed = len_full != prev_len_ext;
    end

    always_comb begin
        pos_next       = pos_reg;
        ovf_next       = ovf_reg;
        have_prev_next = have_prev_reg;
        prev_len_next  = prev_len_reg;
        valid_next     = valid_reg && !item_take;
        if (accept) begin
            valid_next = 1'b1;
            if (s_last_byte) begin
                pos_next = '0;
                ovf_next = 1'b0;
                if (overflow_now) begin
                    have_prev_next = 1'b0;
                    prev_len_next  = '0;
                end else begin
                    have_prev_next = 1'b1;
                    prev_len_next  = len_full[LEN_W-1:0];
                end
            end else begin
                pos_next = pos_inc;
                ovf_next = overflow_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_len_reg  <= '0;
            valid_reg     <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            have_prev_reg <= have_prev_next;
            prev_len_reg  <= prev_len_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/rmsu_verdict.sv
// byte compare, mismatch accumulation and verdict output register
module rmsu_verdict
    import rmsu_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_valid,
    input  rmsu_item_t    item,
    output logic          item_take,
    input  logic [7:0]    rd_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_forward,
    output logic [2:0]    m_verdict_code
);

    logic          mism_reg, mism_next;
    logic          m_valid_reg, m_valid_next;
    verdict_code_t code_reg, code_next;
    logic          consume, mism_acc, out_free;

    assign out_free  = !m_valid_reg || m_ready;
    // only a final byte needs room in the output register
    assign item_take = !item.last || out_free;
    assign consume   = item_valid && item_take;
    assign mism_acc  = mism_reg || (item.cmp_en && (rd_data != item.data));

    always_comb begin
        if (item.too_long) begin
            code_next = VC_TOO_LONG;
        end else if (item.first) begin
            code_next = VC_FIRST;
        end else if (item.disabled) begin
            code_next = VC_DISABLED;
        end else if (item.len_changed) begin
            code_next = VC_LEN_CHANGED;
        end else if (mism_acc) begin
            code_next = VC_CONTENT;
        end else begin
            code_next = VC_DUPLICATE;
        end
    end

    always_comb begin
        mism_next    = mism_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (consume) begin
            if (item.last) begin
                mism_next    = 1'b0;
                m_valid_next = 1'b1;
            end else begin
                mism_next = mism_acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mism_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mism_reg    <= mism_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && item.last) begin
            code_reg <= code_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict_code = code_reg;
    assign m_forward      = code_reg != VC_DUPLICATE;

endmodule

// File: sv/repeat_message_suppressor_unit.sv
// top level of the repeat message suppressor
//
// message bytes enter on the s_ channel, one transaction per byte, with
// s_last_byte on the final byte. one verdict transaction leaves on the
// m_ channel per message: m_forward and m_verdict_code.
// a byte is taken in every cycle for as long as the receiver keeps up;
// each needs one read-compare-write of the payload store: the read and
// the write are issued when the byte is taken, the compare happens on the
// registered read data. the verdict enters the output register when its
// final byte passes the compare stage.
// if the receiver stalls, the pending verdict holds in the output register
// and bytes keep flowing until the next final byte reaches the compare
// stage, which then waits, and s_ready falls until the verdict is taken.
// reset (aresetn low, synchronous) clears positions, flags and the
// previous length, sets header_offset to 0 and filter_enable to 1; the
// store needs no clearing since only entries already written are compared.
// configuration is written through cfg_wr_en, cfg_index and cfg_wr_data;
// the user must write it only while no message is in flight, which the block itself does not enforce.
module repeat_message_suppressor_unit
    import rmsu_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_forward,
    output logic [2:0] m_verdict_code
);

    localparam int ADDR_W = $clog2(MAX_MESSAGE_BYTES);

    logic [7:0]        hdr_reg;
    logic              en_reg;
    logic              item_valid, item_take;
    rmsu_item_t        item;
    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= '0;
            en_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HEADER_OFFSET: hdr_reg <= cfg_wr_data;
                CFG_FILTER_ENABLE: en_reg  <= cfg_wr_data[0];
                default:           hdr_reg <= hdr_reg;
            endcase
        end
    end

    rmsu_track #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
        .ADDR_W           (ADDR_W)
    ) u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .header_offset(hdr_reg),
        .filter_enable(en_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .item_take    (item_take),
        .item_valid   (item_valid),
        .item         (item),
        .ram_wr_en    (ram_wr_en),
        .ram_rd_en    (ram_rd_en),
        .ram_addr     (ram_addr)
    );

    rmsu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE_BYTES),
        .ADDR_W(ADDR_W)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_addr),
        .wr_data(s_data_byte),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_addr),
        .rd_data(rd_data)
    );

    rmsu_verdict u_verdict (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_forward     (m_forward),
        .m_verdict_code(m_verdict_code)
    );

endmodule
